// ===== design/ptbl_pkg.sv =====
package ptbl_pkg;

  // Default sizes of the client table and of the timestamp arithmetic.
  localparam int CLIENT_ENTRIES_DEF = 256;
  localparam int TIME_BITS_DEF      = 32;

  // The client index field is 8 bits wide, so no more than 256 slots are reachable.
  localparam int MAX_SLOTS = 256;

  // Field widths.
  localparam int INDEX_W = 8;
  localparam int STAMP_W = 32;
  localparam int RATE_W  = 16;
  localparam int TOKEN_W = 16;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 24;

  // Register reset values.
  localparam logic [RATE_W-1:0]  RATE_RESET  = 16'd60;
  localparam logic [TOKEN_W-1:0] BURST_RESET = 16'd10;

  // One minute in milliseconds.
  localparam logic [15:0] MS_PER_MINUTE = 16'd60000;

  // A product of elapsed time and rate at or above this value earns 65536 or more tokens.
  localparam logic [47:0] SAT_PRODUCT = 48'd3932160000;

  // Division by 60000: shift right by 5, then multiply by ceil(2^38 / 1875) and shift
  // right by 38. The result is exact for every product below the saturation bound.
  localparam int          PRE_SHIFT   = 5;
  localparam int          RECIP_SHIFT = 38;
  localparam int          SCALED_W    = 27;
  localparam int          RECIP_W     = 28;
  localparam logic [27:0] RECIP_MULT  = 28'd146601551;

  // Configuration register indexes.
  typedef enum logic {
    CFG_RATE  = 1'b0,
    CFG_BURST = 1'b1
  } ptbl_cfg_idx_t;

  // Per-request flags that travel down the pipeline.
  typedef struct packed {
    logic fresh;  // first request for this client since reset
    logic added;  // the refill adds at least one token
  } ptbl_flags_t;

  // Stage strobes: capture a new item, and hand the current item on.
  typedef struct packed {
    logic load;
    logic commit;
  } ptbl_step_t;

endpackage

// ===== design/ptbl_time_stage.sv =====
module ptbl_time_stage #(
  parameter int DEPTH     = ptbl_pkg::MAX_SLOTS,
  parameter int SLOT_W    = 8,
  parameter int TIME_BITS = ptbl_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ptbl_pkg::ptbl_step_t          step,
  input  logic [SLOT_W-1:0]             in_slot,
  input  logic [ptbl_pkg::STAMP_W-1:0]  in_time,
  input  logic [ptbl_pkg::RATE_W-1:0]   rate,
  output logic [SLOT_W-1:0]             s1_slot,
  output ptbl_pkg::ptbl_flags_t         s1_flags,
  output logic [31:0]                   s1_elapsed_lo,
  output logic                          s1_elapsed_hi
);

  logic [TIME_BITS-1:0] stamp_mem [DEPTH];
  logic [TIME_BITS-1:0] stamp_rd_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [TIME_BITS-1:0] now_r;
  logic [DEPTH-1:0]     seen_r;
  logic [DEPTH-1:0]     seen_nxt;
  logic                 fwd_vld_r;
  logic                 fwd_vld_nxt;
  logic [SLOT_W-1:0]    fwd_slot_r;
  logic [TIME_BITS-1:0] fwd_time_r;

  logic                 fresh;
  logic [TIME_BITS-1:0] last_time;
  logic [TIME_BITS-1:0] elapsed;
  logic [63:0]          elapsed_ext;
  logic                 long_gap;
  logic [31:0]          short_prod;
  logic                 added;
  logic [TIME_BITS-1:0] new_last;

  // Timestamp store: read when a request is taken in, written when it moves on.
  always_ff @(posedge clk) begin
    if (step.load) begin
      stamp_rd_r <= stamp_mem[in_slot];
    end
    if (step.commit) begin
      stamp_mem[slot_r] <= new_last;
    end
  end

  // Request payload for this stage.
  always_ff @(posedge clk) begin
    if (step.load) begin
      slot_r <= in_slot;
      now_r  <= TIME_BITS'(in_time);
    end
  end

  // The newest timestamp write is kept here, since the store returns the old
  // value when it is read and written at one address in the same cycle.
  always_ff @(posedge clk) begin
    if (step.commit) begin
      fwd_slot_r <= slot_r;
      fwd_time_r <= new_last;
    end
  end

  always_comb begin
    seen_nxt    = seen_r;
    fwd_vld_nxt = fwd_vld_r;
    if (step.commit) begin
      seen_nxt[slot_r] = 1'b1;
      fwd_vld_nxt      = 1'b1;
    end
  end

  // Client seen bits and forward valid; reset clears the whole table.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r    <= '0;
      fwd_vld_r <= 1'b0;
    end else begin
      seen_r    <= seen_nxt;
      fwd_vld_r <= fwd_vld_nxt;
    end
  end

  // Pick the last refill time: a new client starts now, otherwise the newest write wins.
  always_comb begin
    fresh = !seen_r[slot_r];
    if (fresh) begin
      last_time = now_r;
    end else if (fwd_vld_r && (fwd_slot_r == slot_r)) begin
      last_time = fwd_time_r;
    end else begin
      last_time = stamp_rd_r;
    end
  end

  // Elapsed time wraps with the timestamp width. At least one token is earned
  // when elapsed times rate reaches one minute; beyond a minute any nonzero rate does.
  always_comb begin
    elapsed     = now_r - last_time;
    elapsed_ext = 64'(elapsed);
    long_gap    = (|elapsed_ext[63:16]) || (elapsed_ext[15:0] >= ptbl_pkg::MS_PER_MINUTE);
    short_prod  = 32'(elapsed_ext[15:0]) * 32'(rate);
    added       = (rate != '0) && (long_gap || (short_prod >= 32'(ptbl_pkg::MS_PER_MINUTE)));
    new_last    = added ? now_r : last_time;
  end

  assign s1_slot        = slot_r;
  assign s1_flags.fresh = fresh;
  assign s1_flags.added = added;
  assign s1_elapsed_lo  = elapsed_ext[31:0];
  assign s1_elapsed_hi  = |elapsed_ext[63:32];

endmodule

// ===== design/ptbl_earn_calc.sv =====
module ptbl_earn_calc #(
  parameter int SLOT_W = 8
) (
  input  logic                          clk,
  input  ptbl_pkg::ptbl_step_t          step,
  input  logic [SLOT_W-1:0]             s1_slot,
  input  ptbl_pkg::ptbl_flags_t         s1_flags,
  input  logic [31:0]                   s1_elapsed_lo,
  input  logic                          s1_elapsed_hi,
  input  logic [ptbl_pkg::RATE_W-1:0]   rate,
  output logic [SLOT_W-1:0]             s3_slot,
  output ptbl_pkg::ptbl_flags_t         s3_flags,
  output logic                          s3_sat,
  output logic [ptbl_pkg::TOKEN_W-1:0]  s3_quot
);

  logic [SLOT_W-1:0]                  slot2_r;
  ptbl_pkg::ptbl_flags_t              flags2_r;
  logic [31:0]                        elapsed2_r;
  logic                               hi2_r;
  logic [SLOT_W-1:0]                  slot3_r;
  ptbl_pkg::ptbl_flags_t              flags3_r;
  logic                               sat3_r;
  logic [ptbl_pkg::SCALED_W-1:0]      scaled3_r;

  logic [47:0]                                           prod;
  logic                                                  sat;
  logic [ptbl_pkg::SCALED_W+ptbl_pkg::RECIP_W-1:0]       recip_prod;

  // Stage 2 capture.
  always_ff @(posedge clk) begin
    if (step.load) begin
      slot2_r    <= s1_slot;
      flags2_r   <= s1_flags;
      elapsed2_r <= s1_elapsed_lo;
      hi2_r      <= s1_elapsed_hi;
    end
  end

  // Elapsed times rate; anything at or above the bound earns the capped amount.
  always_comb begin
    prod = 48'(elapsed2_r) * 48'(rate);
    sat  = (rate != '0) && (hi2_r || (prod >= ptbl_pkg::SAT_PRODUCT));
  end

  // Stage 3 capture: below the bound the product fits 32 bits, so drop its low 5 bits.
  always_ff @(posedge clk) begin
    if (step.commit) begin
      slot3_r   <= slot2_r;
      flags3_r  <= flags2_r;
      sat3_r    <= sat;
      scaled3_r <= prod[ptbl_pkg::PRE_SHIFT +: ptbl_pkg::SCALED_W];
    end
  end

  // Reciprocal multiply finishes the division by 60000.
  assign recip_prod = (ptbl_pkg::SCALED_W+ptbl_pkg::RECIP_W)'(scaled3_r)
                    * (ptbl_pkg::SCALED_W+ptbl_pkg::RECIP_W)'(ptbl_pkg::RECIP_MULT);

  assign s3_slot  = slot3_r;
  assign s3_flags = flags3_r;
  assign s3_sat   = sat3_r;
  assign s3_quot  = recip_prod[ptbl_pkg::RECIP_SHIFT +: ptbl_pkg::TOKEN_W];

endmodule

// ===== design/ptbl_token_stage.sv =====
module ptbl_token_stage #(
  parameter int DEPTH  = ptbl_pkg::MAX_SLOTS,
  parameter int SLOT_W = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ptbl_pkg::ptbl_step_t          step,
  input  logic [SLOT_W-1:0]             s3_slot,
  input  ptbl_pkg::ptbl_flags_t         s3_flags,
  input  logic                          s3_sat,
  input  logic [ptbl_pkg::TOKEN_W-1:0]  s3_quot,
  input  logic [ptbl_pkg::TOKEN_W-1:0]  burst,
  output logic                          res_allowed,
  output logic [ptbl_pkg::TOKEN_W-1:0]  res_tokens
);

  logic [ptbl_pkg::TOKEN_W-1:0] tok_mem [DEPTH];
  logic [ptbl_pkg::TOKEN_W-1:0] tok_rd_r;
  logic [SLOT_W-1:0]            slot_r;
  ptbl_pkg::ptbl_flags_t        flags_r;
  logic                         sat_r;
  logic [ptbl_pkg::TOKEN_W-1:0] quot_r;
  logic                         hist_vld_r;
  logic                         hist_vld_nxt;
  logic [SLOT_W-1:0]            hist_slot_r;
  logic [ptbl_pkg::TOKEN_W-1:0] hist_tok_r;
  logic                         allowed_r;
  logic [ptbl_pkg::TOKEN_W-1:0] tokens_r;

  logic [ptbl_pkg::TOKEN_W-1:0] tok_in;
  logic [ptbl_pkg::TOKEN_W:0]   earned;
  logic [ptbl_pkg::TOKEN_W:0]   sum;
  logic [ptbl_pkg::TOKEN_W-1:0] refilled;
  logic [ptbl_pkg::TOKEN_W-1:0] tok_mid;
  logic                         allow;
  logic [ptbl_pkg::TOKEN_W-1:0] tok_out;

  // Token store: read as a request enters this stage, written as it leaves.
  always_ff @(posedge clk) begin
    if (step.load) begin
      tok_rd_r <= tok_mem[s3_slot];
    end
    if (step.commit) begin
      tok_mem[slot_r] <= tok_out;
    end
  end

  // Request payload for the final stage.
  always_ff @(posedge clk) begin
    if (step.load) begin
      slot_r  <= s3_slot;
      flags_r <= s3_flags;
      sat_r   <= s3_sat;
      quot_r  <= s3_quot;
    end
  end

  // Newest token write and the result register.
  always_ff @(posedge clk) begin
    if (step.commit) begin
      hist_slot_r <= slot_r;
      hist_tok_r  <= tok_out;
      allowed_r   <= allow;
      tokens_r    <= tok_out;
    end
  end

  assign hist_vld_nxt = hist_vld_r || step.commit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= 1'b0;
    end else begin
      hist_vld_r <= hist_vld_nxt;
    end
  end

  // Current count: a new client starts full, a just-written count is forwarded.
  always_comb begin
    if (flags_r.fresh) begin
      tok_in = burst;
    end else if (hist_vld_r && (hist_slot_r == slot_r)) begin
      tok_in = hist_tok_r;
    end else begin
      tok_in = tok_rd_r;
    end
  end

  // Refill capped at the burst size, then spend one token if any is left.
  always_comb begin
    earned   = sat_r ? {1'b1, {ptbl_pkg::TOKEN_W{1'b0}}} : {1'b0, quot_r};
    sum      = {1'b0, tok_in} + earned;
    refilled = (sum < {1'b0, burst}) ? sum[ptbl_pkg::TOKEN_W-1:0] : burst;
    tok_mid  = flags_r.added ? refilled : tok_in;
    allow    = (tok_mid != '0);
    tok_out  = allow ? (tok_mid - 1'b1) : tok_mid;
  end

  assign res_allowed = allowed_r;
  assign res_tokens  = tokens_r;

endmodule

// ===== design/per_client_token_bucket_limiter.sv =====
// A request passes the time, earn and token stages and the result register, which drives
// out_tvalid. One request per cycle unless out_tready holds the output, also back to back
// from one client, since the refill-time check and the token update forward new writes.
// Reset clears the client table's seen bits and the pipeline, and sets the rate to 60 and
// the burst size to 10; the timestamp and token stores are not cleared.
module per_client_token_bucket_limiter #(
  parameter int CLIENT_ENTRIES = ptbl_pkg::CLIENT_ENTRIES_DEF,
  parameter int TIME_BITS      = ptbl_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ptbl_pkg::IN_W-1:0]     in_tdata,   // client_index [7:0], current_time [39:8]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ptbl_pkg::OUT_W-1:0]    out_tdata,  // allowed [0], tokens_left [16:1], zero [23:17]
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [ptbl_pkg::RATE_W-1:0]   cfg_wdata
);

  localparam int DEPTH  = (CLIENT_ENTRIES < ptbl_pkg::MAX_SLOTS) ?
                          CLIENT_ENTRIES : ptbl_pkg::MAX_SLOTS;
  localparam int SLOT_W = $clog2(DEPTH);

  logic [ptbl_pkg::RATE_W-1:0]  rate_r;
  logic [ptbl_pkg::RATE_W-1:0]  rate_nxt;
  logic [ptbl_pkg::TOKEN_W-1:0] burst_r;
  logic [ptbl_pkg::TOKEN_W-1:0] burst_nxt;

  logic v1_r, v2_r, v3_r, v4_r, out_vld_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt, out_vld_nxt;
  logic adv1, adv2, adv3, adv4;
  logic accept;

  logic [SLOT_W-1:0]            slot_lut [ptbl_pkg::MAX_SLOTS];
  logic [SLOT_W-1:0]            in_slot;
  logic [SLOT_W-1:0]            s1_slot;
  ptbl_pkg::ptbl_flags_t        s1_flags;
  logic [31:0]                  s1_elapsed_lo;
  logic                         s1_elapsed_hi;
  logic [SLOT_W-1:0]            s3_slot;
  ptbl_pkg::ptbl_flags_t        s3_flags;
  logic                         s3_sat;
  logic [ptbl_pkg::TOKEN_W-1:0] s3_quot;
  logic                         res_allowed;
  logic [ptbl_pkg::TOKEN_W-1:0] res_tokens;

  ptbl_pkg::ptbl_step_t         time_step;
  ptbl_pkg::ptbl_step_t         earn_step;
  ptbl_pkg::ptbl_step_t         token_step;

  // Configuration registers.
  always_comb begin
    rate_nxt  = rate_r;
    burst_nxt = burst_r;
    if (cfg_we) begin
      case (ptbl_pkg::ptbl_cfg_idx_t'(cfg_index))
        ptbl_pkg::CFG_RATE:  rate_nxt  = cfg_wdata;
        ptbl_pkg::CFG_BURST: burst_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= ptbl_pkg::RATE_RESET;
      burst_r <= ptbl_pkg::BURST_RESET;
    end else begin
      rate_r  <= rate_nxt;
      burst_r <= burst_nxt;
    end
  end

  // Client index to table slot, reduced modulo the table size.
  for (genvar g = 0; g < ptbl_pkg::MAX_SLOTS; g++) begin : g_slot_lut
    assign slot_lut[g] = SLOT_W'(g % CLIENT_ENTRIES);
  end

  assign in_slot = slot_lut[in_tdata[ptbl_pkg::INDEX_W-1:0]];

  // Pipeline flow: a stage moves on when the stage after it is empty or moving too.
  always_comb begin
    adv4      = v4_r && (!out_vld_r || out_tready);
    adv3      = v3_r && (!v4_r || adv4);
    adv2      = v2_r && (!v3_r || adv3);
    adv1      = v1_r && (!v2_r || adv2);
    in_tready = !v1_r || adv1;
    accept    = in_tvalid && in_tready;
  end

  always_comb begin
    v1_nxt      = accept ? 1'b1 : (adv1 ? 1'b0 : v1_r);
    v2_nxt      = adv1   ? 1'b1 : (adv2 ? 1'b0 : v2_r);
    v3_nxt      = adv2   ? 1'b1 : (adv3 ? 1'b0 : v3_r);
    v4_nxt      = adv3   ? 1'b1 : (adv4 ? 1'b0 : v4_r);
    out_vld_nxt = adv4   ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      v1_r      <= v1_nxt;
      v2_r      <= v2_nxt;
      v3_r      <= v3_nxt;
      v4_r      <= v4_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign time_step.load     = accept;
  assign time_step.commit   = adv1;
  assign earn_step.load     = adv1;
  assign earn_step.commit   = adv2;
  assign token_step.load    = adv3;
  assign token_step.commit  = adv4;

  // Stage 1: refill-time decision and timestamp update.
  ptbl_time_stage #(
    .DEPTH     (DEPTH),
    .SLOT_W    (SLOT_W),
    .TIME_BITS (TIME_BITS)
  ) u_time (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (time_step),
    .in_slot       (in_slot),
    .in_time       (in_tdata[ptbl_pkg::INDEX_W +: ptbl_pkg::STAMP_W]),
    .rate          (rate_r),
    .s1_slot       (s1_slot),
    .s1_flags      (s1_flags),
    .s1_elapsed_lo (s1_elapsed_lo),
    .s1_elapsed_hi (s1_elapsed_hi)
  );

  // Stages 2 and 3: tokens earned over the elapsed time.
  ptbl_earn_calc #(
    .SLOT_W (SLOT_W)
  ) u_earn (
    .clk           (clk),
    .step          (earn_step),
    .s1_slot       (s1_slot),
    .s1_flags      (s1_flags),
    .s1_elapsed_lo (s1_elapsed_lo),
    .s1_elapsed_hi (s1_elapsed_hi),
    .rate          (rate_r),
    .s3_slot       (s3_slot),
    .s3_flags      (s3_flags),
    .s3_sat        (s3_sat),
    .s3_quot       (s3_quot)
  );

  // Stage 4: token count update, decision and result register.
  ptbl_token_stage #(
    .DEPTH  (DEPTH),
    .SLOT_W (SLOT_W)
  ) u_token (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (token_step),
    .s3_slot     (s3_slot),
    .s3_flags    (s3_flags),
    .s3_sat      (s3_sat),
    .s3_quot     (s3_quot),
    .burst       (burst_r),
    .res_allowed (res_allowed),
    .res_tokens  (res_tokens)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(ptbl_pkg::OUT_W - ptbl_pkg::TOKEN_W - 1){1'b0}}, res_tokens, res_allowed};

endmodule
